@@ rtl/core/alj_pkg.sv @@
// alj_pkg: shared opcodes, widths and flag record for the 64-bit long alu
// no dependencies
`default_nettype none
package alj_pkg;

  localparam int unsigned DataWidth = 64;
  localparam int unsigned KindWidth = 4;
  localparam int unsigned ShiftWidth = 8;
  localparam int unsigned QueueDepth = 2;

  localparam logic [KindWidth-1:0] KindAdd  = 4'd0;
  localparam logic [KindWidth-1:0] KindSub  = 4'd1;
  localparam logic [KindWidth-1:0] KindMul  = 4'd2;
  localparam logic [KindWidth-1:0] KindAnd  = 4'd3;
  localparam logic [KindWidth-1:0] KindOr   = 4'd4;
  localparam logic [KindWidth-1:0] KindXor  = 4'd5;
  localparam logic [KindWidth-1:0] KindNot  = 4'd6;
  localparam logic [KindWidth-1:0] KindNeg  = 4'd7;
  localparam logic [KindWidth-1:0] KindShl  = 4'd8;
  localparam logic [KindWidth-1:0] KindShr  = 4'd9;
  localparam logic [KindWidth-1:0] KindSar  = 4'd10;
  localparam logic [KindWidth-1:0] KindSdiv = 4'd11;
  localparam logic [KindWidth-1:0] KindSrem = 4'd12;
  localparam logic [KindWidth-1:0] KindUdiv = 4'd13;
  localparam logic [KindWidth-1:0] KindUrem = 4'd14;

  // compare and logical flags, worked out once in the front
  typedef struct packed {
    logic equal;
    logic less_signed;
    logic greater_signed;
    logic less_unsigned;
    logic greater_unsigned;
    logic a_is_zero;
    logic both_nonzero;
    logic either_nonzero;
    logic divide_by_zero;
  } flags_t;

  localparam int unsigned FlagsWidth = $bits(flags_t);

endpackage
`default_nettype wire

@@ rtl/core/alj_front.sv @@
// alj_front: request intake, operand compares and divide-by-zero detection
// depends on alj_pkg
`default_nettype none
module alj_front #(
  parameter int unsigned DATA_WIDTH = alj_pkg::DataWidth
) (
  input  wire logic                           valid_i,
  input  wire logic                           full_i,
  input  wire logic [alj_pkg::KindWidth-1:0]  kind_i,
  input  wire logic [DATA_WIDTH-1:0]          operand_a_i,
  input  wire logic [DATA_WIDTH-1:0]          operand_b_i,
  output logic                                stall_o,
  output logic                                push_o,
  output alj_pkg::flags_t                     flags_o
);

  logic is_div;
  logic a_nz;
  logic b_nz;

  assign is_div = (kind_i == alj_pkg::KindSdiv) || (kind_i == alj_pkg::KindSrem) ||
                  (kind_i == alj_pkg::KindUdiv) || (kind_i == alj_pkg::KindUrem);
  assign a_nz = |operand_a_i;
  assign b_nz = |operand_b_i;

  assign stall_o = full_i;
  assign push_o  = valid_i && !full_i;

  always_comb begin
    flags_o.equal            = (operand_a_i == operand_b_i);
    flags_o.less_signed      = ($signed(operand_a_i) < $signed(operand_b_i));
    flags_o.greater_signed   = ($signed(operand_a_i) > $signed(operand_b_i));
    flags_o.less_unsigned    = (operand_a_i < operand_b_i);
    flags_o.greater_unsigned = (operand_a_i > operand_b_i);
    flags_o.a_is_zero        = !a_nz;
    flags_o.both_nonzero     = a_nz && b_nz;
    flags_o.either_nonzero   = a_nz || b_nz;
    flags_o.divide_by_zero   = is_div && !b_nz;
  end

endmodule
`default_nettype wire

@@ rtl/core/alj_queue.sv @@
// alj_queue: small request queue between front and back
// depends on alj_pkg
`default_nettype none
module alj_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic                  full_o,
  output logic                  empty_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int unsigned Depth = alj_pkg::QueueDepth;
  localparam int unsigned PtrW = $clog2(Depth);

  logic [WIDTH-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/alj_back.sv @@
// alj_back: execution pipeline with split multiplier and one-bit-a-stage divider
// depends on alj_pkg
`default_nettype none
module alj_back #(
  parameter int unsigned DATA_WIDTH = alj_pkg::DataWidth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  input  wire logic [alj_pkg::KindWidth-1:0]  kind_i,
  input  wire logic [DATA_WIDTH-1:0]          operand_a_i,
  input  wire logic [DATA_WIDTH-1:0]          operand_b_i,
  input  wire logic [alj_pkg::ShiftWidth-1:0] shift_amount_i,
  input  wire alj_pkg::flags_t                flags_i,
  output logic                                pop_o,
  output logic                                valid_o,
  input  wire logic                           stall_i,
  output logic [DATA_WIDTH-1:0]               result_o,
  output alj_pkg::flags_t                     flags_o
);

  localparam int unsigned W = DATA_WIDTH;
  localparam int unsigned H = DATA_WIDTH / 2;
  localparam int unsigned SW = $clog2(DATA_WIDTH);

  typedef struct packed {
    logic [alj_pkg::KindWidth-1:0] kind;
    alj_pkg::flags_t               flags;
    logic [W-1:0]                  res;
    logic [W-1:0]                  rem;
    logic [W-1:0]                  quo;
    logic [W-1:0]                  dvs;
    logic                          neg_q;
    logic                          neg_r;
    logic [H-1:0]                  pp_lh;
    logic [H-1:0]                  pp_hl;
  } stage_t;

  stage_t       stg_q [W+1];
  logic [W:0]   vld_q;
  logic         adv;
  stage_t       s0;
  logic         is_signed;
  logic         na, nb;
  logic         big_shift;
  logic [SW-1:0] sh;
  logic [W-1:0] res_out;
  logic [W-1:0] res_q;
  alj_pkg::flags_t flags_q;
  logic         out_v_q;

  assign adv   = !out_v_q || !stall_i;
  assign pop_o = adv && valid_i;

  // decode and first stage
  always_comb begin
    is_signed = (kind_i == alj_pkg::KindSdiv) || (kind_i == alj_pkg::KindSrem);
    na        = is_signed && operand_a_i[W-1];
    nb        = is_signed && operand_b_i[W-1];
    big_shift = |shift_amount_i[alj_pkg::ShiftWidth-1:SW];
    sh        = shift_amount_i[SW-1:0];
    s0.kind   = kind_i;
    s0.flags  = flags_i;
    s0.rem    = '0;
    s0.quo    = na ? -operand_a_i : operand_a_i;
    s0.dvs    = nb ? -operand_b_i : operand_b_i;
    s0.neg_q  = na ^ nb;
    s0.neg_r  = na;
    s0.pp_lh  = operand_a_i[H-1:0] * operand_b_i[W-1:H];
    s0.pp_hl  = operand_a_i[W-1:H] * operand_b_i[H-1:0];
    unique case (kind_i)
      alj_pkg::KindAdd: s0.res = operand_a_i + operand_b_i;
      alj_pkg::KindSub: s0.res = operand_a_i - operand_b_i;
      alj_pkg::KindMul: s0.res = W'(operand_a_i[H-1:0]) * W'(operand_b_i[H-1:0]);
      alj_pkg::KindAnd: s0.res = operand_a_i & operand_b_i;
      alj_pkg::KindOr:  s0.res = operand_a_i | operand_b_i;
      alj_pkg::KindXor: s0.res = operand_a_i ^ operand_b_i;
      alj_pkg::KindNot: s0.res = ~operand_a_i;
      alj_pkg::KindNeg: s0.res = -operand_a_i;
      alj_pkg::KindShl: s0.res = big_shift ? '0 : operand_a_i << sh;
      alj_pkg::KindShr: s0.res = big_shift ? '0 : operand_a_i >> sh;
      alj_pkg::KindSar: begin
        s0.res = big_shift ? {W{operand_a_i[W-1]}}
                           : W'($signed(operand_a_i) >>> sh);
      end
      alj_pkg::KindSdiv, alj_pkg::KindUdiv: s0.res = '1;
      alj_pkg::KindSrem, alj_pkg::KindUrem: s0.res = operand_a_i;
      default: s0.res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stg_q[0] <= s0;
    end
  end

  // one quotient bit per stage; stage one also folds in the cross products
  for (genvar i = 1; i <= W; i++) begin : g_step
    stage_t     nx;
    logic [W:0] part;
    logic [W:0] trial;
    always_comb begin
      nx    = stg_q[i-1];
      part  = {stg_q[i-1].rem, stg_q[i-1].quo[W-1]};
      trial = part - {1'b0, stg_q[i-1].dvs};
      if (!trial[W]) begin
        nx.rem = trial[W-1:0];
        nx.quo = {stg_q[i-1].quo[W-2:0], 1'b1};
      end else begin
        nx.rem = part[W-1:0];
        nx.quo = {stg_q[i-1].quo[W-2:0], 1'b0};
      end
      if (i == 1 && stg_q[i-1].kind == alj_pkg::KindMul) begin
        nx.res = stg_q[i-1].res + {stg_q[i-1].pp_lh + stg_q[i-1].pp_hl, {H{1'b0}}};
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        stg_q[i] <= nx;
      end
    end
  end

  always_comb begin
    res_out = stg_q[W].res;
    if (!stg_q[W].flags.divide_by_zero) begin
      unique case (stg_q[W].kind)
        alj_pkg::KindSdiv: res_out = stg_q[W].neg_q ? -stg_q[W].quo : stg_q[W].quo;
        alj_pkg::KindSrem: res_out = stg_q[W].neg_r ? -stg_q[W].rem : stg_q[W].rem;
        alj_pkg::KindUdiv: res_out = stg_q[W].quo;
        alj_pkg::KindUrem: res_out = stg_q[W].rem;
        default:           res_out = stg_q[W].res;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= vld_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q   <= res_out;
      flags_q <= stg_q[W].flags;
    end
  end

  assign valid_o  = out_v_q;
  assign result_o = res_q;
  assign flags_o  = flags_q;

endmodule
`default_nettype wire

@@ rtl/core/alu_64bit_java_long.sv @@
// alu_64bit_java_long: top level of the 64-bit long alu
// depends on alj_pkg, alj_front, alj_queue and alj_back
`default_nettype none
// 64-bit integer alu with java long semantics: add, sub, low-half mul, logic,
// not, negate, three shifts (counts of 64 or more shift everything out) and
// signed and unsigned divide and remainder. a zero divisor raises
// divide_by_zero with quotient all ones and remainder equal to the dividend.
// every request also reports compare and logical flags on its operands.
// a front stage classifies the request and works out the flags, a two-entry
// queue sits between it and the back pipeline, so either side can stall on
// its own. one request per cycle is taken and returned while nothing stalls; a
// result passes one set-up stage loaded from the queue, one divider stage per
// quotient bit and one output register. a stalled result freezes the whole
// back pipeline, and the input stalls once the queue holds two requests.
module alu_64bit_java_long #(
  parameter int unsigned DATA_WIDTH = alj_pkg::DataWidth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // request channel
  input  wire logic                           valid_i,
  output logic                                stall_o,
  input  wire logic [alj_pkg::KindWidth-1:0]  kind_i,
  input  wire logic [DATA_WIDTH-1:0]          operand_a_i,
  input  wire logic [DATA_WIDTH-1:0]          operand_b_i,
  input  wire logic [alj_pkg::ShiftWidth-1:0] shift_amount_i,
  // result channel
  output logic                                valid_o,
  input  wire logic                           stall_i,
  output logic [DATA_WIDTH-1:0]               result_o,
  output logic                                equal_o,
  output logic                                less_signed_o,
  output logic                                greater_signed_o,
  output logic                                less_unsigned_o,
  output logic                                greater_unsigned_o,
  output logic                                a_is_zero_o,
  output logic                                both_nonzero_o,
  output logic                                either_nonzero_o,
  output logic                                divide_by_zero_o
);

  localparam int unsigned KW = alj_pkg::KindWidth;
  localparam int unsigned SHW = alj_pkg::ShiftWidth;
  localparam int unsigned FW = alj_pkg::FlagsWidth;
  localparam int unsigned QW = KW + 2 * DATA_WIDTH + SHW + FW;

  logic             full, empty, push, pop;
  alj_pkg::flags_t  front_flags, q_flags, out_flags;
  logic [QW-1:0]    q_in, q_out;
  logic [KW-1:0]    q_kind;
  logic [DATA_WIDTH-1:0] q_a, q_b;
  logic [SHW-1:0]   q_sh;

  // front: classify and compare
  alj_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .valid_i     (valid_i),
    .full_i      (full),
    .kind_i      (kind_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .stall_o     (stall_o),
    .push_o      (push),
    .flags_o     (front_flags)
  );

  assign q_in = {kind_i, operand_a_i, operand_b_i, shift_amount_i, front_flags};

  // decoupling queue
  alj_queue #(.WIDTH(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .data_o  (q_out)
  );

  assign {q_kind, q_a, q_b, q_sh, q_flags} = q_out;

  // back: execution pipeline and output register
  alj_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (!empty),
    .kind_i         (q_kind),
    .operand_a_i    (q_a),
    .operand_b_i    (q_b),
    .shift_amount_i (q_sh),
    .flags_i        (q_flags),
    .pop_o          (pop),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .result_o       (result_o),
    .flags_o        (out_flags)
  );

  assign equal_o            = out_flags.equal;
  assign less_signed_o      = out_flags.less_signed;
  assign greater_signed_o   = out_flags.greater_signed;
  assign less_unsigned_o    = out_flags.less_unsigned;
  assign greater_unsigned_o = out_flags.greater_unsigned;
  assign a_is_zero_o        = out_flags.a_is_zero;
  assign both_nonzero_o     = out_flags.both_nonzero;
  assign either_nonzero_o   = out_flags.either_nonzero;
  assign divide_by_zero_o   = out_flags.divide_by_zero;

`ifndef SYNTHESIS
  // equal operands exclude any ordering
  a_equal_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && equal_o |-> !less_signed_o && !greater_signed_o &&
                           !less_unsigned_o && !greater_unsigned_o)
    else $error("equal result also ordered");

  // a zero first operand cannot have both operands nonzero
  a_zero_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && a_is_zero_o |-> !both_nonzero_o)
    else $error("zero flag contradicts nonzero flag");

  // queue never pops from nothing
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire
